>>> src/cfe_pkg.sv
package cfe_pkg;

  // Default width of reference positions and of the exonic length.
  localparam int POS_BITS_DEF = 32;

  // Fixed field widths of the channels.
  localparam int START_BITS = 32;
  localparam int LEN_BITS   = 28;
  localparam int FIELD_BITS = 32;
  localparam int OP_BITS    = 4;

  // Most results that one operation can cause.
  localparam int MAX_RES = 3;

  // CIGAR operation codes.
  localparam logic [OP_BITS-1:0] OP_M  = 4'd0;
  localparam logic [OP_BITS-1:0] OP_I  = 4'd1;
  localparam logic [OP_BITS-1:0] OP_D  = 4'd2;
  localparam logic [OP_BITS-1:0] OP_N  = 4'd3;
  localparam logic [OP_BITS-1:0] OP_S  = 4'd4;
  localparam logic [OP_BITS-1:0] OP_H  = 4'd5;
  localparam logic [OP_BITS-1:0] OP_P  = 4'd6;
  localparam logic [OP_BITS-1:0] OP_EQ = 4'd7;
  localparam logic [OP_BITS-1:0] OP_X  = 4'd8;

  typedef enum logic [2:0] {
    KIND_INS     = 3'd0,
    KIND_DEL     = 3'd1,
    KIND_INTRON  = 3'd2,
    KIND_EXON    = 3'd3,
    KIND_SUMMARY = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [FIELD_BITS-1:0] from_pos;
    logic [FIELD_BITS-1:0] to_pos;
    logic                  last;
  } result_t;

  function automatic result_t make_res(kind_t k, logic [FIELD_BITS-1:0] f,
                                       logic [FIELD_BITS-1:0] t);
    result_t r;
    r.kind     = k;
    r.from_pos = f;
    r.to_pos   = t;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

>>> src/cigar_feature_extractor.sv
// The first result of an operation is offered in the cycle after its beat is accepted.
// One operation per cycle while each causes at most one result and out_stall is low; an
// operation with several results (up to three) holds the input until its last one leaves the one output port.
// Reset: rst_n is synchronous and active low; it clears the walk state and drops any
// result still waiting.
module cigar_feature_extractor #(
  parameter int POS_BITS = cfe_pkg::POS_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_first_op,
  input  logic [cfe_pkg::START_BITS-1:0]    in_start_pos,
  input  logic [cfe_pkg::OP_BITS-1:0]       in_op_code,
  input  logic [cfe_pkg::LEN_BITS-1:0]      in_op_length,
  input  logic                              in_last_op,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_kind,
  output logic [cfe_pkg::FIELD_BITS-1:0]    out_from_pos,
  output logic [cfe_pkg::FIELD_BITS-1:0]    out_to_pos,
  output logic                              out_last_result
);

  // Width used for the saturating adds: wide enough for a position and an
  // operation length, plus one carry bit.
  localparam int SUM_W  = ((POS_BITS > cfe_pkg::LEN_BITS) ? POS_BITS : cfe_pkg::LEN_BITS) + 1;
  // Width that holds both a position and a 32-bit port field.
  localparam int WIDE_W = (POS_BITS > cfe_pkg::FIELD_BITS) ? POS_BITS : cfe_pkg::FIELD_BITS;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Adds an operation length to a position, clamping at the position maximum.
  function automatic logic [POS_BITS-1:0] sat_add(logic [POS_BITS-1:0] a,
                                                  logic [cfe_pkg::LEN_BITS-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s > SUM_W'(POS_MAX)) begin
      return POS_MAX;
    end
    return s[POS_BITS-1:0];
  endfunction

  // Truncates or zero-extends a position to the width of a port field.
  function automatic logic [cfe_pkg::FIELD_BITS-1:0] to_field(logic [POS_BITS-1:0] v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[cfe_pkg::FIELD_BITS-1:0];
  endfunction

  // Walk state, held across the operations of a record.
  logic [POS_BITS-1:0] ref_r, ref_nxt;
  logic                open_r, open_nxt;
  logic [POS_BITS-1:0] begin_r, begin_nxt;
  logic [POS_BITS-1:0] total_r, total_nxt;

  // Result queue: slot 0 is the head that drives the output port. All results
  // of one operation are loaded at once and then leave one per beat.
  cfe_pkg::result_t res_r [cfe_pkg::MAX_RES];
  cfe_pkg::result_t res_nxt [cfe_pkg::MAX_RES];
  logic [1:0]       cnt_r;
  logic [1:0]       nres;

  logic in_fire;
  logic out_fire;

  // Operation work, all on the accepted beat.
  logic [POS_BITS-1:0] st_ref;
  logic                st_open;
  logic [POS_BITS-1:0] st_total;
  logic [POS_BITS-1:0] ref_adv;
  logic [POS_BITS-1:0] total_adv;
  logic [WIDE_W-1:0]   start_w;

  assign out_valid = (cnt_r != 2'd0);
  assign out_fire  = out_valid && !out_stall;

  // A new operation may enter once the queue is empty or its last waiting
  // result leaves in this cycle.
  assign in_stall = !((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_fire));
  assign in_fire  = in_valid && !in_stall;

  assign out_kind        = res_r[0].kind;
  assign out_from_pos    = res_r[0].from_pos;
  assign out_to_pos      = res_r[0].to_pos;
  assign out_last_result = res_r[0].last;

  always_comb begin
    // A record's first operation resets the walk and loads its start position,
    // clamped to the position maximum.
    start_w = WIDE_W'(in_start_pos);
    if (in_first_op) begin
      st_ref   = (start_w > WIDE_W'(POS_MAX)) ? POS_MAX : start_w[POS_BITS-1:0];
      st_open  = 1'b0;
      st_total = '0;
    end else begin
      st_ref   = ref_r;
      st_open  = open_r;
      st_total = total_r;
    end

    ref_adv   = sat_add(st_ref, in_op_length);
    total_adv = sat_add(st_total, in_op_length);

    ref_nxt   = st_ref;
    open_nxt  = st_open;
    begin_nxt = begin_r;
    total_nxt = st_total;

    nres = 2'd0;
    for (int i = 0; i < cfe_pkg::MAX_RES; i++) begin
      res_nxt[i] = cfe_pkg::make_res(cfe_pkg::KIND_INS, '0, '0);
    end

    case (in_op_code) inside
      cfe_pkg::OP_M, cfe_pkg::OP_EQ, cfe_pkg::OP_X: begin
        // Match-type operations open an exon if none is open and extend it.
        if (!st_open) begin
          open_nxt  = 1'b1;
          begin_nxt = st_ref;
        end
        total_nxt = total_adv;
        ref_nxt   = ref_adv;
      end
      cfe_pkg::OP_I: begin
        res_nxt[nres] = cfe_pkg::make_res(cfe_pkg::KIND_INS, to_field(st_ref),
                                          cfe_pkg::FIELD_BITS'(in_op_length));
        nres = nres + 2'd1;
      end
      cfe_pkg::OP_D: begin
        res_nxt[nres] = cfe_pkg::make_res(cfe_pkg::KIND_DEL, to_field(st_ref),
                                          to_field(ref_adv));
        nres    = nres + 2'd1;
        ref_nxt = ref_adv;
      end
      cfe_pkg::OP_N: begin
        // The intron is reported first; an open exon ends where the skip begins.
        res_nxt[nres] = cfe_pkg::make_res(cfe_pkg::KIND_INTRON, to_field(st_ref),
                                          to_field(ref_adv));
        nres = nres + 2'd1;
        if (st_open) begin
          res_nxt[nres] = cfe_pkg::make_res(cfe_pkg::KIND_EXON, to_field(begin_r),
                                            to_field(st_ref));
          nres     = nres + 2'd1;
          open_nxt = 1'b0;
        end
        ref_nxt = ref_adv;
      end
      default: begin
        // Clips, padding and unused codes consume nothing.
      end
    endcase

    // At the end of a record an exon still open is flushed, then the summary
    // carries the end position and the exonic length.
    if (in_last_op) begin
      if (open_nxt) begin
        res_nxt[nres] = cfe_pkg::make_res(cfe_pkg::KIND_EXON, to_field(begin_nxt),
                                          to_field(ref_nxt));
        nres     = nres + 2'd1;
        open_nxt = 1'b0;
      end
      res_nxt[nres] = cfe_pkg::make_res(cfe_pkg::KIND_SUMMARY, to_field(ref_nxt),
                                        to_field(total_nxt));
      nres = nres + 2'd1;
    end

    if (nres != 2'd0) begin
      res_nxt[nres - 2'd1].last = 1'b1;
    end
  end

  // Walk state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r   <= '0;
      open_r  <= 1'b0;
      begin_r <= '0;
      total_r <= '0;
    end else if (in_fire) begin
      ref_r   <= ref_nxt;
      open_r  <= open_nxt;
      begin_r <= begin_nxt;
      total_r <= total_nxt;
    end
  end

  // Queue occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_fire) begin
      cnt_r <= nres;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Queue payload: loaded on an accepted beat, shifted toward the head on
  // each delivered result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < cfe_pkg::MAX_RES; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < cfe_pkg::MAX_RES - 1; i++) begin
        res_r[i] <= res_r[i + 1];
      end
    end
  end

endmodule
